// File: rtl/blwd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blwd_pkg: shared types and constants of the bounded list with dedup
// Field widths, stream word layouts, command codes and sequencer states.
// ----------------------------------------------------------------------------
package blwd_pkg;

  localparam int VALUE_W      = 32;  // stored value and element width
  localparam int FIELD_W      = 6;   // range index and entry count fields
  localparam int CMD_W        = 2;
  localparam int MAX_RESULTS  = 32;  // longest run of a range read
  localparam int DEF_CAPACITY = 32;

  // Input word: command, value, range_start, range_end, two pad bits.
  localparam int IN_CMD_LSB   = 0;
  localparam int IN_VAL_LSB   = IN_CMD_LSB + CMD_W;
  localparam int IN_START_LSB = IN_VAL_LSB + VALUE_W;
  localparam int IN_END_LSB   = IN_START_LSB + FIELD_W;
  localparam int IN_TDATA_W   = 48;

  // Output word: ok, entry_count, element, one pad bit.
  localparam int OUT_TDATA_W  = 40;
  localparam int CFG_TDATA_W  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_RANGE  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

endpackage : blwd_pkg

`default_nettype wire

// File: rtl/bounded_list_with_dedup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_list_with_dedup: ordered list of signed values with unique insert
// Commands arrive on the in_ stream, one result run per command on out_.
// ----------------------------------------------------------------------------
// Usage. Each in_ word carries one command: insert appends a value, remove
// deletes matching entries and closes the gap, range read returns the stored
// entries of an index window as a run of out_ words ending with tlast.
// Insert and remove always answer with a single word. The cfg_ channel sets
// allow_duplicates; it may only be written while no command is in flight.
// Timing. The list lives in a one-port-read, one-port-write RAM with a
// registered read; one entry is read per cycle unless a range walk waits on
// a stalled receiver. A command that needs no walk (insert with duplicates
// allowed, insert into a full list, an empty range, an unused code) goes
// from acceptance to ST_RESP, which loads its word. An insert with duplicate
// rejection walks the entries up to a match or the end; a remove walks all
// count entries. A range read walks its window, one word per surviving entry.
// A new command is accepted once the previous one has loaded its final word.
// Reset empties the list and sets allow_duplicates. When the receiver stalls,
// the output register holds its word and a range walk pauses on its entry.
// ----------------------------------------------------------------------------
module bounded_list_with_dedup #(
  parameter int CAPACITY = blwd_pkg::DEF_CAPACITY
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata: command[1:0], value[33:2], range_start[39:34], range_end[45:40]
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  input  wire logic [blwd_pkg::IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: ok[0], entry_count[6:1], element[38:7]; out_tuser: has_element
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  output      logic [blwd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output      logic                             out_tuser,
  output      logic                             out_tlast,
  // cfg_tdata: allow_duplicates[0]
  input  wire logic                             cfg_tvalid,
  output      logic                             cfg_tready,
  input  wire logic [blwd_pkg::CFG_TDATA_W-1:0] cfg_tdata
);
  import blwd_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);               // count and index
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int XW = CW + FIELD_W;                       // common compare width
  localparam int GW = $clog2(MAX_RESULTS);
  localparam int NW = $clog2(MAX_RESULTS + 1);

  // Control and working registers.
  state_t             state_r, state_nxt;
  cmd_t               op_r, op_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      ptr_r, ptr_nxt;
  logic [CW-1:0]      end_r, end_nxt;
  logic [CW-1:0]      w_r, w_nxt;
  logic               rem_r, rem_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  logic [MAX_RESULTS-1:0] gv_r, gv_nxt;
  logic [VALUE_W-1:0] pend_r, pend_nxt;
  logic               res_ok_r, res_ok_nxt;
  logic               res_has_r, res_has_nxt;
  logic               allow_r;

  // Input fields.
  logic [CMD_W-1:0]   in_cmd;
  logic [VALUE_W-1:0] in_value;
  logic [XW-1:0]      start_x, end_x, cnt_x, end_c_x;

  assign in_cmd   = in_tdata[IN_CMD_LSB +: CMD_W];
  assign in_value = in_tdata[IN_VAL_LSB +: VALUE_W];
  assign start_x  = XW'(in_tdata[IN_START_LSB +: FIELD_W]);
  assign end_x    = XW'(in_tdata[IN_END_LSB +: FIELD_W]);
  assign cnt_x    = XW'(count_r);
  assign end_c_x  = (end_x > cnt_x) ? cnt_x : end_x;

  // Values already returned by the current range read, compared in parallel.
  logic [VALUE_W-1:0]     got_r [MAX_RESULTS];
  logic                   got_we;
  logic [MAX_RESULTS-1:0] eq_vec;

  // List storage.
  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rdata_r;
  logic [AW-1:0]      raddr, waddr;
  logic [VALUE_W-1:0] wdata;
  logic               we;

  // Output register.
  logic               out_valid_r;
  logic               out_ok_r, out_has_r, out_last_r;
  logic [FIELD_W-1:0] out_cnt_r;
  logic [VALUE_W-1:0] out_el_r;
  logic               out_ld, ld_ok, ld_has, ld_last;
  logic [VALUE_W-1:0] ld_el;
  logic               ofree;

  // Walk decode.
  logic [CW-1:0] ptr_inc;
  logic          last_idx, hit, skip, dup, need_push, done;

  assign ofree     = !out_valid_r || out_tready;
  assign ptr_inc   = ptr_r + CW'(1);
  assign last_idx  = (ptr_inc == end_r);
  assign hit       = (rdata_r == val_r);
  assign skip      = hit && (allow_r || !rem_r);
  assign dup       = !allow_r && |(gv_r & eq_vec);
  assign need_push = !dup && (n_r != '0);
  assign done      = last_idx || (!dup && (n_r == NW'(MAX_RESULTS - 1)));

  always_comb begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      eq_vec[k] = (got_r[k] == rdata_r);
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_tready = 1'b1;

  // Next state, memory port control and output loads.
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    end_nxt     = end_r;
    w_nxt       = w_r;
    rem_nxt     = rem_r;
    val_nxt     = val_r;
    n_nxt       = n_r;
    gv_nxt      = gv_r;
    pend_nxt    = pend_r;
    res_ok_nxt  = res_ok_r;
    res_has_nxt = res_has_r;
    raddr       = ptr_r[AW-1:0];
    we          = 1'b0;
    waddr       = count_r[AW-1:0];
    wdata       = val_r;
    got_we      = 1'b0;
    out_ld      = 1'b0;
    ld_ok       = 1'b1;
    ld_has      = 1'b0;
    ld_last     = 1'b1;
    ld_el       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          val_nxt     = in_value;
          ptr_nxt     = '0;
          end_nxt     = count_r;
          w_nxt       = '0;
          rem_nxt     = 1'b0;
          n_nxt       = '0;
          gv_nxt      = '0;
          res_has_nxt = 1'b0;
          res_ok_nxt  = 1'b1;
          raddr       = '0;
          state_nxt   = ST_RESP;
          unique case (in_cmd)
            CMD_INSERT: begin
              op_nxt = CMD_INSERT;
              if (count_r >= CW'(CAPACITY)) begin
                res_ok_nxt = 1'b0;
              end else if (allow_r || count_r == '0) begin
                we        = 1'b1;
                wdata     = in_value;
                count_nxt = count_r + CW'(1);
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            CMD_REMOVE: begin
              op_nxt = CMD_REMOVE;
              if (count_r != '0) begin
                state_nxt = ST_SCAN;
              end
            end
            CMD_RANGE: begin
              op_nxt = CMD_RANGE;
              if (start_x < end_c_x) begin
                ptr_nxt   = start_x[CW-1:0];
                end_nxt   = end_c_x[CW-1:0];
                raddr     = start_x[AW-1:0];
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              res_ok_nxt = 1'b0;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // rdata_r holds the entry at ptr_r; the next read is issued here.
        ptr_nxt = ptr_inc;
        raddr   = ptr_inc[AW-1:0];
        unique case (op_r)
          CMD_INSERT: begin
            if (hit) begin
              res_ok_nxt = 1'b0;
              state_nxt  = ST_RESP;
            end else if (last_idx) begin
              we        = 1'b1;
              count_nxt = count_r + CW'(1);
              state_nxt = ST_RESP;
            end
          end
          CMD_REMOVE: begin
            // Compaction: every kept entry is copied down to the write index.
            if (skip) begin
              rem_nxt = 1'b1;
            end else begin
              we    = 1'b1;
              waddr = w_r[AW-1:0];
              wdata = rdata_r;
              w_nxt = w_r + CW'(1);
            end
            if (last_idx) begin
              count_nxt = skip ? w_r : w_r + CW'(1);
              state_nxt = ST_RESP;
            end
          end
          CMD_RANGE: begin
            // A new entry is held back until the next one, or the end of the
            // walk, shows whether it is the final word of the run.
            if (need_push && !ofree) begin
              ptr_nxt = ptr_r;
              raddr   = ptr_r[AW-1:0];
            end else begin
              if (!dup) begin
                got_we                = 1'b1;
                gv_nxt[n_r[GW-1:0]]   = 1'b1;
                pend_nxt              = rdata_r;
                n_nxt                 = n_r + NW'(1);
              end
              if (need_push) begin
                out_ld  = 1'b1;
                ld_has  = 1'b1;
                ld_last = 1'b0;
                ld_el   = pend_r;
              end
              if (done) begin
                res_has_nxt = 1'b1;
                state_nxt   = ST_RESP;
              end
            end
          end
          default: begin
            state_nxt = ST_RESP;
          end
        endcase
      end

      ST_RESP: begin
        if (ofree) begin
          out_ld    = 1'b1;
          ld_ok     = res_ok_r;
          ld_has    = res_has_r;
          ld_el     = res_has_r ? pend_r : '0;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      allow_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_tvalid && cfg_tready) begin
        allow_r <= cfg_tdata[0];
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of the current command.
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    ptr_r     <= ptr_nxt;
    end_r     <= end_nxt;
    w_r       <= w_nxt;
    rem_r     <= rem_nxt;
    val_r     <= val_nxt;
    n_r       <= n_nxt;
    gv_r      <= gv_nxt;
    pend_r    <= pend_nxt;
    res_ok_r  <= res_ok_nxt;
    res_has_r <= res_has_nxt;
    if (got_we) begin
      got_r[n_r[GW-1:0]] <= rdata_r;
    end
    if (out_ld) begin
      out_ok_r   <= ld_ok;
      out_has_r  <= ld_has;
      out_last_r <= ld_last;
      out_el_r   <= ld_el;
      out_cnt_r  <= cnt_x[FIELD_W-1:0];
    end
  end

  // List RAM: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_el_r, out_cnt_r, out_ok_r};
  assign out_tuser  = out_has_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ld && out_valid_r) |-> out_tready)
    else $error("output word overwritten while stalled");

  a_walk_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (ptr_r < end_r))
    else $error("walk pointer beyond its window");

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (n_r < NW'(MAX_RESULTS)))
    else $error("range run longer than allowed");
`endif

endmodule : bounded_list_with_dedup

`default_nettype wire
